// File: rtl/ccs_pkg.sv
// ccs_pkg: shared types and character constants for the css comment stripper
// no dependencies; imported by css_comment_stripper, strip_checker and tb_css_comment_stripper
`default_nettype none

package ccs_pkg;

  // character codes that drive the scanner
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // result queue depth; an item may push two words at once
  localparam int unsigned RESULT_DEPTH = 4;

  // scanner state, one-hot
  typedef enum logic [4:0] {
    MODE_NORMAL  = 5'b00001,
    MODE_SLASH   = 5'b00010,
    MODE_COMMENT = 5'b00100,
    MODE_CSTAR   = 5'b01000,
    MODE_STRING  = 5'b10000
  } scan_mode_t;

  // one result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_last;
  } result_t;

endpackage : ccs_pkg

`default_nettype wire

// File: rtl/css_comment_stripper.sv
// css_comment_stripper: removes slash-star block comments from a css byte stream
// depends on ccs_pkg for the scanner state type, character codes and result word
//
// One byte of css text enters per cycle on the s_ side while s_tready is high; bytes
// inside block comments are dropped, quoted strings pass untouched, and a slash is held
// until the following byte shows it does not open a comment. The scanner decides all
// results of a byte in the cycle it is accepted and writes zero, one or two words into
// a small result queue that feeds the m_ side. The sustained rate is one input word per
// cycle while each byte yields at most one word and the m_ side keeps taking words;
// a byte that releases a held slash together with itself yields two words, which the
// queue absorbs and repays by stalling s_tready once it has fewer than two free entries.
// s_tready depends only on registered queue occupancy. The word accepted with s_tlast
// high flushes a held slash, sends an empty word with tuser low if nothing else is due,
// marks its final result with m_tlast, and returns the scanner to plain text. Text of
// a comment still open at the end of the stream is dropped.
`default_nettype none

module css_comment_stripper (
  input  wire logic       clk,
  input  wire logic       rst,
  // input word
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tlast,   // stream_end
  // result word
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tuser,   // [0] byte_valid
  output logic            m_tlast    // is_last
);

  import ccs_pkg::*;

  // queue depth is a power of two so the pointers wrap on their own
  localparam int unsigned DEPTH = RESULT_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // scanner state
  scan_mode_t mode, mode_next;
  logic [7:0] quote, quote_next;

  // result queue
  result_t            queue [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;

  logic               s_fire, m_fire;
  result_t            res [2];
  logic [1:0]         res_cnt;

  assign s_fire = s_tvalid & s_tready;
  assign m_fire = m_tvalid & m_tready;

  // accept only with room for two words
  assign s_tready = (count <= CNT_W'(DEPTH - 2));

  // scanner decision for the incoming byte
  always_comb begin
    mode_next = mode;
    quote_next = quote;
    res_cnt = 2'd0;
    for (int i = 0; i < 2; i++) begin
      res[i] = '0;
    end
    unique case (mode)
      MODE_SLASH: begin
        if (s_tdata == CH_STAR) begin
          mode_next = MODE_COMMENT;
        end else begin
          res[0] = '{out_byte: CH_SLASH, byte_valid: 1'b1, is_last: 1'b0};
          if (s_tdata == CH_SLASH) begin
            res_cnt = 2'd1;
            mode_next = MODE_SLASH;
          end else begin
            res[1] = '{out_byte: s_tdata, byte_valid: 1'b1, is_last: 1'b0};
            res_cnt = 2'd2;
            if (s_tdata == CH_SQUOTE || s_tdata == CH_DQUOTE) begin
              mode_next = MODE_STRING;
              quote_next = s_tdata;
            end else begin
              mode_next = MODE_NORMAL;
            end
          end
        end
      end
      MODE_COMMENT: begin
        if (s_tdata == CH_STAR) begin
          mode_next = MODE_CSTAR;
        end
      end
      MODE_CSTAR: begin
        if (s_tdata == CH_SLASH) begin
          mode_next = MODE_NORMAL;
        end else if (s_tdata != CH_STAR) begin
          mode_next = MODE_COMMENT;
        end
      end
      MODE_STRING: begin
        res[0] = '{out_byte: s_tdata, byte_valid: 1'b1, is_last: 1'b0};
        res_cnt = 2'd1;
        if (s_tdata == quote) begin
          mode_next = MODE_NORMAL;
          quote_next = 8'h00;
        end
      end
      default: begin
        if (s_tdata == CH_SLASH) begin
          mode_next = MODE_SLASH;
        end else begin
          res[0] = '{out_byte: s_tdata, byte_valid: 1'b1, is_last: 1'b0};
          res_cnt = 2'd1;
          if (s_tdata == CH_SQUOTE || s_tdata == CH_DQUOTE) begin
            mode_next = MODE_STRING;
            quote_next = s_tdata;
          end else begin
            mode_next = MODE_NORMAL;
          end
        end
      end
    endcase

    // end of stream: flush held slash, empty marker if nothing due, tag last
    if (s_tlast) begin
      if (mode_next == MODE_SLASH) begin
        res[res_cnt[0]] = '{out_byte: CH_SLASH, byte_valid: 1'b1, is_last: 1'b0};
        res_cnt = res_cnt + 2'd1;
      end
      if (res_cnt == 2'd0) begin
        res[0] = '{out_byte: 8'h00, byte_valid: 1'b0, is_last: 1'b0};
        res_cnt = 2'd1;
      end
      res[res_cnt[0] ^ 1'b1].is_last = 1'b1;
      mode_next = MODE_NORMAL;
      quote_next = 8'h00;
    end
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      quote <= 8'h00;
    end else if (s_fire) begin
      mode <= mode_next;
      quote <= quote_next;
    end
  end

  // queue payload writes
  always_ff @(posedge clk) begin
    if (s_fire) begin
      for (int i = 0; i < 2; i++) begin
        if (2'(i) < res_cnt) begin
          queue[wr_ptr + PTR_W'(i)] <= res[i];
        end
      end
    end
  end

  // queue occupancy
  always_comb begin
    count_next = count;
    if (s_fire) begin
      count_next = count_next + CNT_W'(res_cnt);
    end
    if (m_fire) begin
      count_next = count_next - CNT_W'(1);
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (s_fire) begin
        wr_ptr <= wr_ptr + PTR_W'(res_cnt);
      end
      if (m_fire) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // output word
  assign m_tvalid = (count != '0);
  assign m_tdata  = queue[rd_ptr].out_byte;
  assign m_tuser  = queue[rd_ptr].byte_valid;
  assign m_tlast  = queue[rd_ptr].is_last;

`ifndef ASSERT_OFF
  // queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  // end of stream leaves the scanner in plain text
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tlast |=> mode == MODE_NORMAL && quote == 8'h00)
    else $error("scanner not reset after stream end");

  // every accepted word produces at least one result when it ends a stream
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tlast |-> res_cnt != 2'd0)
    else $error("stream end produced no result");

  // a quote character is held only while inside a string
  a_quote_mode: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_STRING |-> quote == 8'h00)
    else $error("stale quote character");
`endif

endmodule : css_comment_stripper

`default_nettype wire

// File: sim/strip_checker.sv
`timescale 1ns / 1ps
// strip_checker: watches both stream channels of css_comment_stripper and scores results
// depends on ccs_pkg for scanner modes, character codes and the result word layout

module strip_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // stream_end
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] out_byte
  input  logic       m_tuser,   // [0] byte_valid
  input  logic       m_tlast,   // is_last
  output int         errors,
  output int         words_due
);

  import ccs_pkg::*;

  // scanner copy kept in step with the block
  scan_mode_t mode       = MODE_NORMAL;
  logic [7:0] open_quote = 8'h00;

  // words still owed by the block, oldest first
  result_t    due_words[$];
  result_t    step_words[3];
  int         step_n     = 0;
  int         fail_count = 0;
  int         due_count  = 0;

  assign errors    = fail_count;
  assign words_due = due_count;

  function automatic void add_word(input logic [7:0] b, input logic v);
    step_words[step_n] = {b, v, 1'b0};
    step_n++;
  endfunction

  // byte seen in plain text: a slash waits, a quote opens a string
  function automatic void plain_byte(input logic [7:0] b);
    if (b == CH_SLASH) begin
      mode = MODE_SLASH;
    end else begin
      add_word(b, 1'b1);
      if (b == CH_SQUOTE || b == CH_DQUOTE) begin
        mode       = MODE_STRING;
        open_quote = b;
      end else begin
        mode = MODE_NORMAL;
      end
    end
  endfunction

  // advance the scanner by one byte and queue the words it yields
  function automatic void scan_byte(input logic [7:0] b, input logic fin);
    step_n = 0;
    case (mode)
      MODE_SLASH: begin
        if (b == CH_STAR) begin
          mode = MODE_COMMENT;
        end else begin
          add_word(CH_SLASH, 1'b1);
          plain_byte(b);
        end
      end
      MODE_COMMENT: begin
        if (b == CH_STAR) mode = MODE_CSTAR;
      end
      MODE_CSTAR: begin
        if (b == CH_SLASH) mode = MODE_NORMAL;
        else if (b != CH_STAR) mode = MODE_COMMENT;
      end
      MODE_STRING: begin
        add_word(b, 1'b1);
        if (b == open_quote) begin
          mode       = MODE_NORMAL;
          open_quote = 8'h00;
        end
      end
      default: plain_byte(b);
    endcase
    // end of stream: flush a held slash, else an empty marker if nothing went out
    if (fin) begin
      if (mode == MODE_SLASH) add_word(CH_SLASH, 1'b1);
      if (step_n == 0) add_word(8'h00, 1'b0);
      step_words[step_n - 1].is_last = 1'b1;
      mode       = MODE_NORMAL;
      open_quote = 8'h00;
    end
    for (int i = 0; i < step_n; i++) due_words.push_back(step_words[i]);
  endfunction

  // compare outgoing words first: a word leaving now never stems from a byte entering now
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      mode       = MODE_NORMAL;
      open_quote = 8'h00;
      due_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_words.size() == 0) begin
          $error("unexpected word: out_byte %h byte_valid %b is_last %b",
                 m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = due_words.pop_front();
          if (m_tdata !== want.out_byte) begin
            $error("out_byte: expected %h actual %h", want.out_byte, m_tdata);
            fail_count++;
          end
          if (m_tuser !== want.byte_valid) begin
            $error("byte_valid: expected %b actual %b", want.byte_valid, m_tuser);
            fail_count++;
          end
          if (m_tlast !== want.is_last) begin
            $error("is_last: expected %b actual %b", want.is_last, m_tlast);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
    end
    due_count <= due_words.size();
  end

endmodule : strip_checker

// File: sim/tb_css_comment_stripper.sv
`timescale 1ns / 1ps
// tb_css_comment_stripper: drives css text streams into the stripper with random gaps
// depends on ccs_pkg, css_comment_stripper and strip_checker (which does the scoring)

module tb_css_comment_stripper;
  import ccs_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 150;
  localparam int RANDOM_ITEMS = 900;

  // pieces a random stream is built from
  typedef enum int {
    TOK_TEXT,
    TOK_COMMENT,
    TOK_STRING,
    TOK_SLASH,
    TOK_NOISE
  } token_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;  // [7:0] in_byte
  logic       s_tlast  = 1'b0;   // stream_end
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tuser;           // [0] byte_valid
  logic       m_tlast;           // is_last

  int errors;
  int words_due;
  int quiet_cycles = 0;
  int items_sent   = 0;
  bit src_fast     = 1'b0;
  bit sink_fast    = 1'b0;
  bit hold_sink    = 1'b0;

  always #5 clk = ~clk;

  css_comment_stripper i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  strip_checker i_strip_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .errors    (errors),
    .words_due (words_due)
  );

  // watchdog: too long without any word moving ends the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_css_comment_stripper: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls per word, bursts without stalls, one long hold on request
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_sink) begin
        hold_sink = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 31) == 0) sink_fast = ~sink_fast;
      gap = sink_fast ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // one input word; valid stays up across back-to-back words
  task automatic send_word(input logic [7:0] b, input logic fin);
    int gap;
    gap = src_fast ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_word(txt[i], i == txt.len() - 1);
  endtask

  // hold the sender back until the block has delivered everything
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  function automatic logic [7:0] css_char();
    case ($urandom_range(0, 11))
      0:       return CH_SLASH;
      1:       return CH_STAR;
      2:       return CH_SQUOTE;
      3:       return CH_DQUOTE;
      4:       return "{";
      5:       return "}";
      6:       return ":";
      7:       return ";";
      8:       return " ";
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // comment bodies lean on stars and slashes to hit the closer logic
  function automatic logic [7:0] comment_char();
    case ($urandom_range(0, 3))
      0:       return CH_STAR;
      1:       return CH_SLASH;
      default: return css_char();
    endcase
  endfunction

  // mostly well-formed css with comments and strings, some noise, odd tails
  task automatic run_stream(input int max_len);
    logic [7:0] text[$];
    logic [7:0] q;
    int         len;
    len = $urandom_range(1, max_len);
    while (text.size() < len) begin
      case (token_t'($urandom_range(0, 4)))
        TOK_TEXT: repeat ($urandom_range(1, 6)) text.push_back(css_char());
        TOK_COMMENT: begin
          text.push_back(CH_SLASH);
          text.push_back(CH_STAR);
          repeat ($urandom_range(0, 6)) text.push_back(comment_char());
          repeat ($urandom_range(1, 3)) text.push_back(CH_STAR);
          text.push_back(CH_SLASH);
        end
        TOK_STRING: begin
          q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
          text.push_back(q);
          repeat ($urandom_range(0, 5)) text.push_back(comment_char());
          text.push_back(q);
        end
        TOK_SLASH: begin
          repeat ($urandom_range(1, 3)) text.push_back(CH_SLASH);
          text.push_back(css_char());
        end
        default: repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    // tails: open comment, open string, lone slash
    case ($urandom_range(0, 7))
      0: begin
        text.push_back(CH_SLASH);
        text.push_back(CH_STAR);
        repeat ($urandom_range(0, 3)) text.push_back(comment_char());
      end
      1: begin
        text.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
        repeat ($urandom_range(0, 3)) text.push_back(css_char());
      end
      2: text.push_back(CH_SLASH);
      default: ;
    endcase
    foreach (text[i]) send_word(text[i], i == text.size() - 1);
  endtask

  // stimulus and verdict
  initial begin
    int stream_no;
    int stop_at;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // opener star is not a closer star, then a run of stars closes
    send_text("a/*/x**/b");
    // slash after held slash, then the held one flushed at the end
    send_text("//");
    // comment opener inside a double-quoted string
    send_text("\"/*\"");
    // string still open at the end
    send_text("'x");
    // comment still open at the end gives an empty end marker
    send_text("/*c");
    // lone slash flushed by the end
    send_text("/");
    // byte extremes
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    drain_results();

    stream_no = 0;
    stop_at   = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      src_fast = ($urandom_range(0, 3) == 0);
      if (stream_no == 12) begin
        // receiver holds off while the sender keeps pushing; plain text fills the queue
        hold_sink = 1'b1;
        src_fast  = 1'b1;
        send_text("a{b:c;d:e}f{g:h}");
        run_stream(40);
      end else begin
        run_stream(30);
      end
      if (stream_no % 20 == 5) drain_results();
      stream_no++;
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_css_comment_stripper: clean");
    end else begin
      $display("tb_css_comment_stripper: errors");
    end
    $finish;
  end

endmodule : tb_css_comment_stripper
